[sv/ptls_pkg.sv]
// Shared constants for the presence-triggered light sequencer.
package ptls_pkg;

  localparam int TIMER_WIDTH_DEF = 17;

  localparam int DT_W        = 10;
  localparam int DIST_W      = 9;
  localparam int TRIG_W      = 8;
  localparam int COUNTDOWN_W = 17;
  localparam int CLEAR_W     = 12;
  localparam int HITS_W      = 4;
  localparam int SHORT_W     = 13;
  localparam int MODE_W      = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTDOWN_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABORT_CLEAR_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GO_CLEAR_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_HALF_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HITS_NEEDED      = 3'd5;

  localparam logic [TRIG_W-1:0]      RST_TRIGGER_DISTANCE = 8'd100;
  localparam logic [COUNTDOWN_W-1:0] RST_COUNTDOWN_MS     = 17'd10000;
  localparam logic [CLEAR_W-1:0]     RST_ABORT_CLEAR_MS   = 12'd1000;
  localparam logic [CLEAR_W-1:0]     RST_GO_CLEAR_MS      = 12'd500;
  localparam logic [CLEAR_W-1:0]     RST_FLASH_HALF_MS    = 12'd500;
  localparam logic [HITS_W-1:0]      RST_HITS_NEEDED      = 4'd3;

endpackage

[sv/presence_triggered_light_sequencer_core.sv]
// Presence-triggered light sequencer: one light channel, input register and result register.
// The input register captures each accepted word; its result word is registered in the result register.
// Throughput: one word per cycle unless out_stall holds the output; the whole state update
// is one combinational pass between the input register and the state/result registers.
// Reset (rst, synchronous): mode waiting, all timers and counters cleared,
// configuration registers back to their defaults, both pipeline registers empty.
module presence_triggered_light_sequencer_core #(
  parameter int TIMER_WIDTH = ptls_pkg::TIMER_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ptls_pkg::DT_W-1:0]          elapsed_ms,
  input  logic                               fresh,
  input  logic [ptls_pkg::DIST_W-1:0]        distance_cm,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ptls_pkg::MODE_W-1:0]        light_mode,
  output logic                               green_on,
  output logic                               red_on,
  output logic [ptls_pkg::COUNTDOWN_W-1:0]   remaining_ms,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptls_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ptls_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > COUNTDOWN_W) ? TIMER_WIDTH : COUNTDOWN_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_WAITING   = 2'd0,
    MODE_COUNTDOWN = 2'd1,
    MODE_GO        = 2'd2
  } mode_t;

  // configuration
  logic [TRIG_W-1:0]      trigger_distance;
  logic [COUNTDOWN_W-1:0] countdown_ms;
  logic [CLEAR_W-1:0]     abort_clear_ms;
  logic [CLEAR_W-1:0]     go_clear_ms;
  logic [CLEAR_W-1:0]     flash_half_ms;
  logic [HITS_W-1:0]      hits_needed;

  // input register
  logic              s1_valid;
  logic [DT_W-1:0]   s1_elapsed;
  logic              s1_fresh;
  logic [DIST_W-1:0] s1_distance;
  logic              s1_adv;

  // state
  mode_t                  mode;
  logic [HITS_W-1:0]      hit_count;
  logic [TIMER_WIDTH-1:0] countdown_elapsed;
  logic [SHORT_W-1:0]     absent_time;
  logic                   absent_active;
  logic [SHORT_W-1:0]     flash_time;
  logic                   red_flash;
  logic [DIST_W-1:0]      last_distance;

  mode_t                  mode_next;
  logic [HITS_W-1:0]      hit_count_next;
  logic [TIMER_WIDTH-1:0] countdown_elapsed_next;
  logic [SHORT_W-1:0]     absent_time_next;
  logic                   absent_active_next;
  logic [SHORT_W-1:0]     flash_time_next;
  logic                   red_flash_next;
  logic [DIST_W-1:0]      last_distance_next;
  logic [COUNTDOWN_W-1:0] remaining_next;

  logic                   present;
  logic [HITS_W:0]        hit_sum;
  logic [HITS_W-1:0]      hit_sat;
  logic [TIMER_WIDTH:0]   ce_sum;
  logic [TIMER_WIDTH-1:0] ce_sat;
  logic [SHORT_W:0]       ft_sum;
  logic [SHORT_W-1:0]     ft_sat;
  logic [SHORT_W:0]       at_sum;
  logic [SHORT_W-1:0]     at_sat;
  logic [CLEAR_W-1:0]     clear_limit;
  logic                   absence_done;
  logic [CMP_W-1:0]       cd_wide;
  logic [CMP_W-1:0]       ce_wide;
  logic [CMP_W-1:0]       rem_wide;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_distance <= RST_TRIGGER_DISTANCE;
      countdown_ms     <= RST_COUNTDOWN_MS;
      abort_clear_ms   <= RST_ABORT_CLEAR_MS;
      go_clear_ms      <= RST_GO_CLEAR_MS;
      flash_half_ms    <= RST_FLASH_HALF_MS;
      hits_needed      <= RST_HITS_NEEDED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRIGGER_DISTANCE: trigger_distance <= cfg_data[TRIG_W-1:0];
        REG_COUNTDOWN_MS:     countdown_ms     <= cfg_data[COUNTDOWN_W-1:0];
        REG_ABORT_CLEAR_MS:   abort_clear_ms   <= cfg_data[CLEAR_W-1:0];
        REG_GO_CLEAR_MS:      go_clear_ms      <= cfg_data[CLEAR_W-1:0];
        REG_FLASH_HALF_MS:    flash_half_ms    <= cfg_data[CLEAR_W-1:0];
        REG_HITS_NEEDED:      hits_needed      <= cfg_data[HITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_elapsed  <= elapsed_ms;
      s1_fresh    <= fresh;
      s1_distance <= distance_cm;
    end
  end

  always_comb begin
    last_distance_next = s1_fresh ? s1_distance : last_distance;
    present = (last_distance_next != '0) &&
              (last_distance_next < {1'b0, trigger_distance});

    hit_sum = {1'b0, hit_count} + (HITS_W+1)'(1);
    hit_sat = hit_sum[HITS_W] ? '1 : hit_sum[HITS_W-1:0];

    ce_sum = {1'b0, countdown_elapsed} + (TIMER_WIDTH+1)'(s1_elapsed);
    ce_sat = ce_sum[TIMER_WIDTH] ? '1 : ce_sum[TIMER_WIDTH-1:0];

    ft_sum = {1'b0, flash_time} + (SHORT_W+1)'(s1_elapsed);
    ft_sat = ft_sum[SHORT_W] ? '1 : ft_sum[SHORT_W-1:0];

    at_sum = {1'b0, absent_time} + (SHORT_W+1)'(s1_elapsed);
    at_sat = at_sum[SHORT_W] ? '1 : at_sum[SHORT_W-1:0];

    mode_next              = mode;
    hit_count_next         = hit_count;
    countdown_elapsed_next = countdown_elapsed;
    absent_time_next       = absent_time;
    absent_active_next     = absent_active;
    flash_time_next        = flash_time;
    red_flash_next         = red_flash;
    absence_done           = 1'b0;
    clear_limit            = (mode == MODE_COUNTDOWN) ? abort_clear_ms : go_clear_ms;

    // absence tracking, used in countdown and go
    if (present) begin
      absent_active_next = 1'b0;
      absent_time_next   = '0;
    end else if (!absent_active) begin
      absent_active_next = 1'b1;
      absent_time_next   = '0;
    end else begin
      absent_time_next = at_sat;
    end
    if (mode != MODE_WAITING) begin
      absence_done = absent_active_next &&
                     (absent_time_next >= {1'b0, clear_limit});
    end

    ce_wide = CMP_W'(ce_sat);
    cd_wide = CMP_W'(countdown_ms);

    unique case (mode)
      MODE_WAITING: begin
        absent_active_next = absent_active;
        absent_time_next   = absent_time;
        if (present && s1_fresh) begin
          hit_count_next = hit_sat;
          if (hit_sat >= hits_needed) begin
            mode_next              = MODE_COUNTDOWN;
            hit_count_next         = '0;
            countdown_elapsed_next = '0;
            absent_active_next     = 1'b0;
            absent_time_next       = '0;
            flash_time_next        = '0;
            red_flash_next         = 1'b0;
          end
        end else if (s1_fresh) begin
          hit_count_next = '0;
        end
      end
      MODE_COUNTDOWN: begin
        countdown_elapsed_next = ce_sat;
        if (ft_sat >= {1'b0, flash_half_ms}) begin
          red_flash_next  = !red_flash;
          flash_time_next = '0;
        end else begin
          flash_time_next = ft_sat;
        end
        if (absence_done) begin
          mode_next          = MODE_WAITING;
          absent_active_next = 1'b0;
          absent_time_next   = '0;
        end else if (ce_wide >= cd_wide) begin
          mode_next          = MODE_GO;
          absent_active_next = 1'b0;
          absent_time_next   = '0;
        end
      end
      MODE_GO: begin
        if (absence_done) begin
          mode_next          = MODE_WAITING;
          absent_active_next = 1'b0;
          absent_time_next   = '0;
        end
      end
      default: begin
        if (absence_done) begin
          mode_next          = MODE_WAITING;
          absent_active_next = 1'b0;
          absent_time_next   = '0;
        end
      end
    endcase

    rem_wide = cd_wide - CMP_W'(countdown_elapsed_next);
    if (mode_next == MODE_COUNTDOWN && cd_wide > CMP_W'(countdown_elapsed_next)) begin
      remaining_next = rem_wide[COUNTDOWN_W-1:0];
    end else begin
      remaining_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_WAITING;
      hit_count         <= '0;
      countdown_elapsed <= '0;
      absent_time       <= '0;
      absent_active     <= 1'b0;
      flash_time        <= '0;
      red_flash         <= 1'b0;
      last_distance     <= '0;
      out_valid         <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        mode              <= mode_next;
        hit_count         <= hit_count_next;
        countdown_elapsed <= countdown_elapsed_next;
        absent_time       <= absent_time_next;
        absent_active     <= absent_active_next;
        flash_time        <= flash_time_next;
        red_flash         <= red_flash_next;
        last_distance     <= last_distance_next;
        // result word
        light_mode        <= mode_next;
        green_on          <= (mode_next == MODE_GO);
        red_on            <= (mode_next == MODE_WAITING) ||
                             ((mode_next == MODE_COUNTDOWN) && red_flash_next);
        remaining_ms      <= remaining_next;
      end
    end
  end

endmodule
